// File: rtl/sti_pkg.sv
// Shared constants and bundle types of the sensor table interpolator.
package sti_pkg;

   localparam int TEMP_W = 24;
   localparam int CNT_W = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int DIV_STEPS_PER_STAGE = 4;

   localparam int TEMP_MAX_INT = 8388607;
   localparam int TEMP_MIN_INT = -8388608;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   // Register index as decoded from paddr[2].
   localparam logic REG_FALLBACK = 1'b0;

   typedef struct packed {
      logic              no_table;
      logic              below;
      logic              above;
      logic signed [15:0] reading;
      logic signed [15:0] count_lo;
      logic signed [15:0] temp_lo;
      logic signed [15:0] count_hi;
      logic signed [15:0] temp_hi;
   } sti_bracket_type;

   typedef struct packed {
      logic              out_of_range;
      logic              neg;
      logic              zero_div;
      logic signed [15:0] temp_lo;
   } sti_div_side_type;

endpackage

// File: rtl/sti_stream_if.sv
// Valid/ready channel interfaces for requests and responses.
interface sti_req_if;
   logic              valid;
   logic              ready;
   logic              command;
   logic [2:0]        table_select;
   logic [4:0]        entry_index;
   logic signed [15:0] entry_count_value;
   logic signed [15:0] entry_temperature;
   logic              entry_is_last;
   logic signed [15:0] reading;

   modport source(output valid, command, table_select, entry_index, entry_count_value,
                  entry_temperature, entry_is_last, reading, input ready);
   modport sink(input valid, command, table_select, entry_index, entry_count_value,
                entry_temperature, entry_is_last, reading, output ready);
endinterface

interface sti_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [23:0] temperature;
   logic              out_of_range;

   modport source(output valid, temperature, out_of_range, input ready);
   modport sink(input valid, temperature, out_of_range, output ready);
endinterface

// File: rtl/sti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sti_search.sv
// Pipelined binary search over the breakpoint tables, one RAM copy per search step plus two for the bracket ends.
module sti_search #(
   parameter int TABLES = 8,
   parameter int ENTRIES = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     load_en,
   input  logic                     convert_en,
   input  logic [2:0]               table_select,
   input  logic [4:0]               entry_index,
   input  logic signed [15:0]       entry_count_value,
   input  logic signed [15:0]       entry_temperature,
   input  logic                     entry_is_last,
   input  logic signed [15:0]       reading,
   output logic                     busy,
   output logic                     out_valid,
   output sti_pkg::sti_bracket_type out_bracket
);

   localparam int IW = $clog2(ENTRIES);
   localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int AW = TW + IW;
   localparam int DEPTH = 1 << AW;
   localparam int SS = IW;
   localparam int NR = SS + 2;

   typedef struct packed {
      logic              no_table;
      logic [TW-1:0]     tidx;
      logic [IW-1:0]     lo;
      logic [IW-1:0]     hi;
      logic [IW-1:0]     mid;
      logic [IW-1:0]     last;
      logic signed [15:0] reading;
   } srch_type;

   function automatic srch_type search_step(srch_type s, logic [31:0] d);
      srch_type r;
      logic [IW:0] sum;
      r = s;
      if (s.mid > s.lo) begin
         if (s.reading < $signed(d[15:0])) begin
            r.hi = s.mid;
         end else begin
            r.lo = s.mid;
         end
         sum = {1'b0, r.lo} + {1'b0, r.hi};
         r.mid = sum[IW:1];
      end
      return r;
   endfunction

   logic              load_ok;
   logic [TW-1:0]     ld_tidx;
   logic [TW-1:0]     cv_tidx;
   logic [IW-1:0]     ld_idx;
   logic [IW-1:0]     last_ff [TABLES];
   srch_type          entry_in;
   srch_type          st_ff [SS+2];
   srch_type          st_nx [SS+1];
   logic [SS+1:0]     v_ff;
   logic [31:0]       rd_data [NR];
   logic [AW-1:0]     rd_addr [NR];
   srch_type          fin;
   logic signed [15:0] ca;
   logic signed [15:0] cb;

   assign ld_tidx = TW'(table_select);
   assign cv_tidx = TW'(table_select);
   assign ld_idx = IW'(entry_index);
   assign load_ok = load_en && (int'(table_select) < TABLES) && (int'(entry_index) < ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLES; i++) begin
            last_ff[i] <= '0;
         end
      end else if (load_ok && entry_is_last) begin
         last_ff[ld_tidx] <= ld_idx;
      end
   end

   always_comb begin
      entry_in.no_table = !(int'(table_select) < TABLES);
      entry_in.tidx = cv_tidx;
      entry_in.lo = '0;
      entry_in.hi = entry_in.no_table ? '0 : last_ff[cv_tidx];
      entry_in.mid = entry_in.hi >> 1;
      entry_in.last = entry_in.hi;
      entry_in.reading = reading;
   end

   always_comb begin
      st_nx[0] = st_ff[0];
      for (int k = 1; k <= SS; k++) begin
         st_nx[k] = search_step(st_ff[k], rd_data[k-1]);
      end
      for (int k = 0; k < SS; k++) begin
         rd_addr[k] = {st_nx[k].tidx, st_nx[k].mid};
      end
      rd_addr[SS] = {st_nx[SS].tidx, st_nx[SS].lo};
      rd_addr[SS+1] = {st_nx[SS].tidx, st_nx[SS].hi};
   end

   // Every copy takes every load so that each search step has its own read port.
   for (genvar g = 0; g < NR; g++) begin : g_copy
      sti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
         .clock  (clock),
         .wr_en  (load_ok),
         .wr_addr({ld_tidx, ld_idx}),
         .wr_data({entry_temperature, entry_count_value}),
         .rd_en  (advance),
         .rd_addr(rd_addr[g]),
         .rd_data(rd_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[SS:0], convert_en};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0] <= entry_in;
         for (int k = 1; k <= SS + 1; k++) begin
            st_ff[k] <= st_nx[k-1];
         end
      end
   end

   assign busy = |v_ff[SS:0];
   assign out_valid = v_ff[SS+1];
   assign fin = st_ff[SS+1];
   assign ca = $signed(rd_data[SS][15:0]);
   assign cb = $signed(rd_data[SS+1][15:0]);

   always_comb begin
      out_bracket.no_table = fin.no_table;
      out_bracket.below = (fin.lo == '0) && (fin.reading < ca);
      out_bracket.above = (fin.hi == fin.last) && (fin.reading > cb);
      out_bracket.reading = fin.reading;
      out_bracket.count_lo = ca;
      out_bracket.temp_lo = $signed(rd_data[SS][31:16]);
      out_bracket.count_hi = cb;
      out_bracket.temp_hi = $signed(rd_data[SS+1][31:16]);
   end

endmodule

// File: rtl/sti_divider.sv
// Pipelined restoring divider, DIV_STEPS_PER_STAGE (four) quotient bits per stage.
module sti_divider #(
   parameter int NUM_W = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [NUM_W-1:0]          in_num,
   input  logic [15:0]               in_den,
   input  sti_pkg::sti_div_side_type in_side,
   output logic                      out_valid,
   output logic [NUM_W-1:0]          out_quo,
   output sti_pkg::sti_div_side_type out_side
);

   localparam int STEP = sti_pkg::DIV_STEPS_PER_STAGE;
   localparam int DS = (NUM_W + STEP - 1) / STEP;
   localparam int PW = DS * STEP;

   typedef struct packed {
      logic [PW-1:0]             num;
      logic [PW-1:0]             quo;
      logic [15:0]               rem;
      logic [15:0]               den;
      sti_pkg::sti_div_side_type side;
   } dstage_type;

   function automatic dstage_type div_group(dstage_type s);
      dstage_type r;
      logic [16:0] part;
      r = s;
      for (int i = 0; i < STEP; i++) begin
         part = {r.rem, r.num[PW-1]};
         r.num = r.num << 1;
         if (part >= {1'b0, r.den}) begin
            part = part - {1'b0, r.den};
            r.quo = {r.quo[PW-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[PW-2:0], 1'b0};
         end
         r.rem = part[15:0];
      end
      return r;
   endfunction

   logic [DS-1:0] v_ff;
   dstage_type    s_ff [DS];
   dstage_type    s_in [DS];
   dstage_type    s_first;

   always_comb begin
      s_first.num = PW'(in_num);
      s_first.quo = '0;
      s_first.rem = '0;
      s_first.den = in_den;
      s_first.side = in_side;
      s_in[0] = div_group(s_first);
      for (int k = 1; k < DS; k++) begin
         s_in[k] = div_group(s_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= DS'({v_ff, in_valid});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DS; k++) begin
            s_ff[k] <= s_in[k];
         end
      end
   end

   assign out_valid = v_ff[DS-1];
   assign out_quo = s_ff[DS-1].quo[NUM_W-1:0];
   assign out_side = s_ff[DS-1].side;

endmodule

// File: rtl/sensor_table_interpolator_top.sv
// Top level of the sensor table interpolator: channels, arithmetic stages and register port.
//
// Requests arrive on req_bus. A load beat (command 0) writes one breakpoint into a table
// and produces no response. A convert beat (command 1) looks up the reading in the chosen
// table and returns one response beat on rsp_bus: the interpolated temperature with
// FRAC_BITS fraction bits, or the fallback register value with out_of_range set.
// The fallback temperature is to be written by the user through the csr_ port only while
// the block is idle; the block itself does not enforce this. A convert passes an entry
// register, one stage per search step with its own table copy, a stage reading the bracket
// ends, then difference, multiply and magnitude stages, a divider retiring four quotient
// bits per stage, and the response register. Converts enter back to back, one per cycle,
// unless a waiting response holds the pipeline. A load waits until no convert is still
// reading the tables. When rsp_bus.ready is low with a response waiting, the whole
// pipeline holds and req_bus.ready drops; nothing is lost or repeated. Reset empties
// the pipeline, clears the final indexes of all tables and the fallback register;
// table contents are kept and must be loaded before use.
module sensor_table_interpolator_top #(
   parameter int TABLES = 8,
   parameter int ENTRIES = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   sti_req_if.sink                     req_bus,
   sti_rsp_if.source                   rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sti_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sti_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sti_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int RES_W = NUM_W + 2;
   localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(sti_pkg::TEMP_MAX_INT);
   localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(sti_pkg::TEMP_MIN_INT);

   logic                      advance;
   logic                      busy;
   logic                      accept;
   logic                      load_en;
   logic                      convert_en;
   logic                      srch_valid;
   sti_pkg::sti_bracket_type  bracket;

   logic                      e_v_ff;
   logic                      e_oor_ff;
   logic signed [15:0]        e_ta_ff;
   logic signed [16:0]        e_dr_ff;
   logic signed [16:0]        e_dt_ff;
   logic signed [16:0]        e_dc_ff;
   logic signed [16:0]        dr_in;
   logic signed [16:0]        dt_in;
   logic signed [16:0]        dc_in;

   logic                      m_v_ff;
   logic                      m_oor_ff;
   logic signed [15:0]        m_ta_ff;
   logic signed [33:0]        m_prod_ff;
   logic signed [16:0]        m_dc_ff;
   logic signed [33:0]        prod_in;
   logic signed [33:0]        prod_neg;
   logic signed [16:0]        dc_neg;

   logic                      a_v_ff;
   logic [NUM_W-1:0]          a_num_ff;
   logic [15:0]               a_den_ff;
   sti_pkg::sti_div_side_type a_side_ff;
   logic [31:0]               mag_in;
   logic [15:0]               den_in;
   sti_pkg::sti_div_side_type side_in;

   logic                      d_valid;
   logic [NUM_W-1:0]          d_quo;
   sti_pkg::sti_div_side_type d_side;
   logic signed [RES_W-1:0]   base;
   logic signed [RES_W-1:0]   q_ext;
   logic signed [RES_W-1:0]   res;
   logic signed [23:0]        sat;
   logic signed [23:0]        temp_in;

   logic                      rsp_valid_ff;
   logic signed [23:0]        rsp_temp_ff;
   logic                      rsp_oor_ff;
   logic signed [23:0]        fallback_ff;
   logic                      csr_wr;

   // A waiting response freezes every stage at once.
   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance && ((req_bus.command == sti_pkg::CMD_CONVERT) || !busy);
   assign accept = req_bus.valid && req_bus.ready;
   assign load_en = accept && (req_bus.command == sti_pkg::CMD_LOAD);
   assign convert_en = accept && (req_bus.command == sti_pkg::CMD_CONVERT);

   sti_search #(.TABLES(TABLES), .ENTRIES(ENTRIES)) u_search (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .load_en          (load_en),
      .convert_en       (convert_en),
      .table_select     (req_bus.table_select),
      .entry_index      (req_bus.entry_index),
      .entry_count_value(req_bus.entry_count_value),
      .entry_temperature(req_bus.entry_temperature),
      .entry_is_last    (req_bus.entry_is_last),
      .reading          (req_bus.reading),
      .busy             (busy),
      .out_valid        (srch_valid),
      .out_bracket      (bracket)
   );

   assign dr_in = bracket.reading - bracket.count_lo;
   assign dt_in = bracket.temp_hi - bracket.temp_lo;
   assign dc_in = bracket.count_hi - bracket.count_lo;

   assign prod_in = e_dr_ff * e_dt_ff;

   assign prod_neg = -m_prod_ff;
   assign dc_neg = -m_dc_ff;
   assign mag_in = m_prod_ff[33] ? prod_neg[31:0] : m_prod_ff[31:0];
   assign den_in = m_dc_ff[16] ? dc_neg[15:0] : m_dc_ff[15:0];

   always_comb begin
      side_in.out_of_range = m_oor_ff;
      side_in.neg = m_prod_ff[33] ^ m_dc_ff[16];
      side_in.zero_div = (m_dc_ff == '0);
      side_in.temp_lo = m_ta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         e_v_ff <= srch_valid;
         m_v_ff <= e_v_ff;
         a_v_ff <= m_v_ff;
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_oor_ff <= bracket.no_table || bracket.below || bracket.above;
         e_ta_ff <= bracket.temp_lo;
         e_dr_ff <= dr_in;
         e_dt_ff <= dt_in;
         e_dc_ff <= dc_in;
         m_oor_ff <= e_oor_ff;
         m_ta_ff <= e_ta_ff;
         m_prod_ff <= prod_in;
         m_dc_ff <= e_dc_ff;
         a_num_ff <= NUM_W'(mag_in) << FRAC_BITS;
         a_den_ff <= den_in;
         a_side_ff <= side_in;
         rsp_temp_ff <= temp_in;
         rsp_oor_ff <= d_side.out_of_range;
      end
   end

   sti_divider #(.NUM_W(NUM_W)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (a_v_ff),
      .in_num   (a_num_ff),
      .in_den   (a_den_ff),
      .in_side  (a_side_ff),
      .out_valid(d_valid),
      .out_quo  (d_quo),
      .out_side (d_side)
   );

   // Quotient is the magnitude truncated toward zero; the sign goes on afterwards.
   assign base = RES_W'($signed(d_side.temp_lo)) <<< FRAC_BITS;
   assign q_ext = $signed(RES_W'(d_quo));

   always_comb begin
      if (d_side.zero_div) begin
         res = base;
      end else if (d_side.neg) begin
         res = base - q_ext;
      end else begin
         res = base + q_ext;
      end
      if (res > SAT_HI) begin
         sat = SAT_HI[23:0];
      end else if (res < SAT_LO) begin
         sat = SAT_LO[23:0];
      end else begin
         sat = res[23:0];
      end
      temp_in = d_side.out_of_range ? fallback_ff : sat;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.temperature = rsp_temp_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_ff <= '0;
      end else if (csr_wr && (csr_paddr[2] == sti_pkg::REG_FALLBACK)) begin
         fallback_ff <= csr_pwdata[23:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == sti_pkg::REG_FALLBACK) ?
                       sti_pkg::CSR_DW'(fallback_ff) : '0;

endmodule

// File: rtl/sti_checker.sv
// Port-level checks of the interpolator and their attachment to the top level.
module sti_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [23:0] rsp_temperature,
   input logic              rsp_out_of_range
);

   // A stalled response beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature)
                                  && $stable(rsp_out_of_range))
   else $error("response beat changed while stalled");

   // The pipeline holds as a whole, so no request is taken behind a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
   else $error("request accepted while the response stage is stalled");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("response valid right after reset");

endmodule

bind sensor_table_interpolator_top sti_port_checker u_sti_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_temperature (rsp_bus.temperature),
   .rsp_out_of_range(rsp_bus.out_of_range)
);
